// ===== hw/rtl/bwlpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwlpg_pkg
// Shared widths, limits, register indexes and fixed-point helpers for the
// Butterworth lowpass gain pipeline.
// ----------------------------------------------------------------------------
package bwlpg_pkg;

   localparam int FREQ_W     = 24;
   localparam int GAIN_FRAC  = 16;
   localparam int GAIN_W     = GAIN_FRAC + 1;
   localparam int CUT_W      = 23;
   localparam int ORD_W      = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 23;
   localparam int LOG_STEPS  = 16;
   localparam int EXP1_STEPS = 16;
   localparam int EXP2_STEPS = 17;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER  = 1'b1;

   localparam logic [CUT_W-1:0] CUTOFF_RESET = 23'd1048576;
   localparam logic [ORD_W-1:0] ORDER_RESET  = 8'd1;

   localparam logic [30:0]        Q30_ONE   = 31'h4000_0000;
   localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'h10000;
   // passband / stopband limits of y (log2 domain, Q.16)
   localparam logic signed [31:0] Y_PASS_LIMIT = 32'sd3309196;
   localparam logic signed [31:0] Y_STOP_LIMIT = 32'sd3498293;

   // sideband that travels with every stage
   typedef struct packed {
      logic              valid;
      logic              frc;
      logic [GAIN_W-1:0] fg;
   } side_type;

   // floored integer square root, used only at elaboration
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] xv;
      r  = '0;
      b  = 64'h4000_0000_0000_0000;
      xv = x;
      for (int i = 0; i < 32; i++) begin
         if (xv >= r + b) begin
            xv = xv - (r + b);
            r  = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // root 2^(2^-k) in Q1.30, k >= 1
   function automatic logic [30:0] root_q30(input int k);
      logic [63:0] r;
      r = 64'h8000_0000;
      for (int i = 1; i <= EXP2_STEPS; i++) begin
         if (i <= k) begin
            r = isqrt64(r << 30);
         end
      end
      return r[30:0];
   endfunction

   // Q1.30 square, truncated, result below 4.0
   function automatic logic [31:0] sq_q30(input logic [30:0] m);
      logic [61:0] me;
      logic [61:0] p;
      me = 62'(m);
      p  = me * me;
      return p[61:30];
   endfunction

   // Q1.30 product, truncated, result below 2.0
   function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] p;
      p = 62'(a) * 62'(b);
      return p[60:30];
   endfunction

endpackage

// ===== hw/rtl/butterworth_lowpass_gain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// butterworth_lowpass_gain
// Butterworth lowpass magnitude 1/sqrt(1+(|f|/fc)^(2n)) as a Q1.16 gain.
// ----------------------------------------------------------------------------
// Usage: raise start with a signed frequency on req_freq; the request is taken
// at that edge. busy stays low, so a new request can be given every cycle.
// rsp_strobe rises once the request has passed the input, log2, y, exp2,
// log2(1+t), exp2 and output register stages, and stays high for one cycle
// with rsp_gain (65536 = 1.0); results come out in request order. The
// receiver cannot stall and nothing holds results back.
// Throughput is one request per cycle: the log2, exp2 and log2(1+t) stages
// each resolve one fraction bit per pipeline stage with truncated Q1.30
// multiplies, so the depth is set by the 16 + 16 + 16 + 17 bit steps plus
// the setup and rounding stages.
// Cutoff and order are written through csr_we/csr_index/csr_wdata; change
// them only while no request is in flight. Reset clears the pipeline valid
// bits and loads cutoff 1048576 and order 1.
// ----------------------------------------------------------------------------
module butterworth_lowpass_gain
   import bwlpg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [FREQ_W-1:0] req_freq,
   output logic                    rsp_strobe,
   output logic [GAIN_W-1:0]       rsp_gain,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   typedef struct packed {
      side_type   sd;
      logic [4:0]  ea;
      logic [4:0]  ec;
      logic [30:0] ma;
      logic [30:0] mc;
      logic [15:0] fa;
      logic [15:0] fc;
   } la_type;

   typedef struct packed {
      side_type    sd;
      logic [30:0] acc;
      logic [15:0] f;
      logic [5:0]  sh;
      logic [21:0] ypos;
   } ex_type;

   typedef struct packed {
      side_type    sd;
      logic [30:0] m;
      logic [15:0] f;
      logic        two;
      logic [21:0] ypos;
   } lg_type;

   typedef struct packed {
      side_type    sd;
      logic [30:0] acc;
      logic [16:0] f;
      logic [5:0]  sh;
   } e2_type;

   logic [CUT_W-1:0]  cutoff_ff;
   logic [ORD_W-1:0]  order_ff;
   logic              s0_valid_ff;
   logic [FREQ_W-1:0] s0_a_ff;
   logic [FREQ_W-1:0] s0_a_in;
   la_type            la_ff [0:LOG_STEPS];
   la_type            la_in [0:LOG_STEPS];
   side_type          y_sd_ff;
   logic signed [30:0] y_ff;
   side_type          y_sd_in;
   logic signed [30:0] y_in;
   ex_type            ex_ff [0:EXP1_STEPS];
   ex_type            ex_in [0:EXP1_STEPS];
   lg_type            lg_ff [0:LOG_STEPS];
   lg_type            lg_in [0:LOG_STEPS];
   e2_type            e2_ff [0:EXP2_STEPS];
   e2_type            e2_in [0:EXP2_STEPS];
   logic              rsp_strobe_ff;
   logic [GAIN_W-1:0] rsp_gain_ff;
   logic [GAIN_W-1:0] rsp_gain_in;

   assign busy       = 1'b0;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_gain   = rsp_gain_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUTOFF_RESET;
         order_ff  <= ORDER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CUTOFF: cutoff_ff <= csr_wdata[CUT_W-1:0];
            CSR_ORDER:  order_ff  <= csr_wdata[ORD_W-1:0];
            default:    ;
         endcase
      end
   end

   // absolute frequency
   assign s0_a_in = req_freq[FREQ_W-1] ? FREQ_W'(-req_freq) : FREQ_W'(req_freq);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start;
      end
      s0_a_ff <= s0_a_in;
   end

   // normalize both operands to Q1.30, special cases ride along
   always_comb begin
      logic [4:0] ea;
      logic [4:0] ec;
      ea = '0;
      ec = '0;
      for (int i = 0; i < FREQ_W; i++) begin
         if (s0_a_ff[i]) ea = 5'(i);
      end
      for (int i = 0; i < CUT_W; i++) begin
         if (cutoff_ff[i]) ec = 5'(i);
      end
      la_in[0].sd.valid = s0_valid_ff;
      la_in[0].sd.frc   = (cutoff_ff == '0) || (s0_a_ff == '0);
      la_in[0].sd.fg    = (cutoff_ff == '0) ? '0 : GAIN_ONE;
      la_in[0].ea = ea;
      la_in[0].ec = ec;
      la_in[0].ma = 31'({7'b0, s0_a_ff} << (5'd30 - ea));
      la_in[0].mc = 31'({8'b0, cutoff_ff} << (5'd30 - ec));
      la_in[0].fa = '0;
      la_in[0].fc = '0;
   end

   // log2 fraction by repeated squaring, one bit per stage
   for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log_a
      always_comb begin
         logic [31:0] qa;
         logic [31:0] qc;
         qa = sq_q30(la_ff[k].ma);
         qc = sq_q30(la_ff[k].mc);
         la_in[k+1]    = la_ff[k];
         la_in[k+1].ma = qa[31] ? qa[31:1] : qa[30:0];
         la_in[k+1].mc = qc[31] ? qc[31:1] : qc[30:0];
         la_in[k+1].fa = {la_ff[k].fa[14:0], qa[31]};
         la_in[k+1].fc = {la_ff[k].fc[14:0], qc[31]};
      end
   end

   for (genvar k = 0; k <= LOG_STEPS; k++) begin : g_la_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            la_ff[k].sd.valid <= 1'b0;
         end else begin
            la_ff[k] <= la_in[k];
         end
      end
   end

   // y = 2n * (log2|f| - log2 fc)
   always_comb begin
      logic signed [21:0] d;
      logic signed [31:0] p;
      d = $signed({1'b0, la_ff[LOG_STEPS].ea, la_ff[LOG_STEPS].fa})
        - $signed({1'b0, la_ff[LOG_STEPS].ec, la_ff[LOG_STEPS].fc});
      p = 32'(d) * $signed({22'b0, order_ff, 1'b0});
      y_in    = p[30:0];
      y_sd_in = la_ff[LOG_STEPS].sd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_sd_ff.valid <= 1'b0;
      end else begin
         y_sd_ff <= y_sd_in;
      end
      y_ff <= y_in;
   end

   // band limits, split |y| into shift and fraction
   always_comb begin
      logic signed [31:0] yw;
      logic [29:0]        uy;
      yw = 32'(y_ff);
      uy = y_ff[30] ? 30'(-yw) : 30'(yw);
      ex_in[0].sd = y_sd_ff;
      if (!y_sd_ff.frc) begin
         if (yw >= Y_STOP_LIMIT) begin
            ex_in[0].sd.frc = 1'b1;
            ex_in[0].sd.fg  = '0;
         end else if (yw <= -Y_PASS_LIMIT) begin
            ex_in[0].sd.frc = 1'b1;
            ex_in[0].sd.fg  = GAIN_ONE;
         end
      end
      ex_in[0].acc  = Q30_ONE;
      ex_in[0].f    = 16'(-uy[15:0]);
      ex_in[0].sh   = uy[21:16] + 6'(uy[15:0] != '0);
      ex_in[0].ypos = (yw > 0) ? y_ff[21:0] : '0;
   end

   // 2^(-frac) by product of roots
   for (genvar k = 0; k < EXP1_STEPS; k++) begin : g_exp1
      localparam logic [30:0] ROOT = root_q30(k + 1);
      always_comb begin
         ex_in[k+1] = ex_ff[k];
         if (ex_ff[k].f[EXP1_STEPS-1-k]) ex_in[k+1].acc = mul_q30(ex_ff[k].acc, ROOT);
      end
   end

   for (genvar k = 0; k <= EXP1_STEPS; k++) begin : g_ex_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            ex_ff[k].sd.valid <= 1'b0;
         end else begin
            ex_ff[k] <= ex_in[k];
         end
      end
   end

   // x = 1 + 2^-|y|
   always_comb begin
      logic [30:0] t;
      logic [31:0] x;
      t = ex_ff[EXP1_STEPS].acc >> ex_ff[EXP1_STEPS].sh;
      x = 32'(Q30_ONE) + 32'(t);
      lg_in[0].sd   = ex_ff[EXP1_STEPS].sd;
      lg_in[0].two  = x[31];
      lg_in[0].m    = x[31] ? Q30_ONE : x[30:0];
      lg_in[0].f    = '0;
      lg_in[0].ypos = ex_ff[EXP1_STEPS].ypos;
   end

   // log2(1 + t) fraction
   for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log_t
      always_comb begin
         logic [31:0] q;
         q = sq_q30(lg_ff[k].m);
         lg_in[k+1]   = lg_ff[k];
         lg_in[k+1].m = q[31] ? q[31:1] : q[30:0];
         lg_in[k+1].f = {lg_ff[k].f[14:0], q[31]};
      end
   end

   for (genvar k = 0; k <= LOG_STEPS; k++) begin : g_lg_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            lg_ff[k].sd.valid <= 1'b0;
         end else begin
            lg_ff[k] <= lg_in[k];
         end
      end
   end

   // h = max(y,0) + log2(1+t), then h/2 as shift and Q.17 fraction
   always_comb begin
      logic [16:0] l1;
      logic [22:0] h;
      l1 = lg_ff[LOG_STEPS].two ? 17'h10000 : {1'b0, lg_ff[LOG_STEPS].f};
      h  = 23'(lg_ff[LOG_STEPS].ypos) + 23'(l1);
      e2_in[0].sd  = lg_ff[LOG_STEPS].sd;
      e2_in[0].acc = Q30_ONE;
      e2_in[0].f   = 17'(-h[16:0]);
      e2_in[0].sh  = 6'(h[22:17]) + 6'(h[16:0] != '0);
   end

   // 2^(-h/2) fraction
   for (genvar k = 0; k < EXP2_STEPS; k++) begin : g_exp2
      localparam logic [30:0] ROOT = root_q30(k + 1);
      always_comb begin
         e2_in[k+1] = e2_ff[k];
         if (e2_ff[k].f[EXP2_STEPS-1-k]) e2_in[k+1].acc = mul_q30(e2_ff[k].acc, ROOT);
      end
   end

   for (genvar k = 0; k <= EXP2_STEPS; k++) begin : g_e2_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            e2_ff[k].sd.valid <= 1'b0;
         end else begin
            e2_ff[k] <= e2_in[k];
         end
      end
   end

   // round half up to Q1.16 and clamp
   always_comb begin
      logic [6:0]  total;
      logic [63:0] g;
      total = 7'(30 - GAIN_FRAC) + 7'(e2_ff[EXP2_STEPS].sh);
      g = (64'(e2_ff[EXP2_STEPS].acc) + (64'd1 << (total - 7'd1))) >> total;
      if (e2_ff[EXP2_STEPS].sd.frc) begin
         rsp_gain_in = e2_ff[EXP2_STEPS].sd.fg;
      end else if (g > 64'(GAIN_ONE)) begin
         rsp_gain_in = GAIN_ONE;
      end else begin
         rsp_gain_in = g[GAIN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= e2_ff[EXP2_STEPS].sd.valid;
      end
      rsp_gain_ff <= rsp_gain_in;
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks butterworth_lowpass_gain against a bit-exact fixed-point predictor:
// a directed table (extremes, zero cutoff, zero frequency, far passband and
// stopband, most negative frequency, order zero) followed by random phases
// with bursty requests and register changes between phases.
// ----------------------------------------------------------------------------
module testbench;
   import bwlpg_pkg::*;

   localparam longint unsigned Q30_1 = 64'd1 << 30;
   localparam longint unsigned Q30_2 = 64'd1 << 31;
   localparam int LATENCY  = 72;
   localparam int WATCHDOG = 3000;
   localparam int NO_CHECK = -1;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [FREQ_W-1:0] req_freq;
   logic                     rsp_strobe;
   logic [GAIN_W-1:0]        rsp_gain;
   logic                     csr_we;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;

   butterworth_lowpass_gain dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_freq(req_freq), .rsp_strobe(rsp_strobe), .rsp_gain(rsp_gain),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // predictor copy of the registers
   logic [CUT_W-1:0] cur_cutoff;
   logic [ORD_W-1:0] cur_order;

   logic [GAIN_W-1:0] gain_queue[$];
   int errors;
   int idle_cycles;
   bit accepted_now;

   // floored integer square root
   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // fraction bits of log2 of a Q1.30 mantissa by repeated squaring
   function automatic longint unsigned log2_mant(longint unsigned m);
      longint unsigned f;
      f = 0;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         f = f << 1;
         if (m >= Q30_2) begin
            f = f | 1;
            m = m >> 1;
         end
      end
      return f;
   endfunction

   // log2 of x >= 1 in Q.16
   function automatic longint log2_q16(longint unsigned x);
      int e;
      longint unsigned m;
      e = 63;
      while (e > 0 && x[e] == 1'b0) e--;
      m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
      return longint'(e) * 65536 + longint'(log2_mant(m));
   endfunction

   // 2^(f/2^bits) in Q1.30 as a product of successive roots of two
   function automatic longint unsigned pow2_frac(longint unsigned f, int bits);
      longint unsigned acc, root;
      acc = Q30_1;
      root = Q30_2;
      for (int i = 1; i <= bits; i++) begin
         root = int_sqrt(root << 30);
         if ((f >> (bits - i)) & 1) acc = (acc * root) >> 30;
      end
      return acc;
   endfunction

   function automatic logic [GAIN_W-1:0] predict_gain(logic [FREQ_W-1:0] v,
         logic [CUT_W-1:0] fc, logic [ORD_W-1:0] n);
      logic [FREQ_W-1:0] a;
      longint d, y;
      longint unsigned uy, ni, fr, m, sh, t, x, l1, h, ip, fp, g;
      int total;
      a = v[FREQ_W-1] ? (~v + 1'b1) : v;
      if (fc == 0) return '0;
      if (a == 0) return GAIN_ONE;
      d = log2_q16(longint'(a)) - log2_q16(longint'(fc));
      y = 2 * longint'(n) * d;
      if (y >= longint'(Y_STOP_LIMIT)) return '0;
      if (y <= -longint'(Y_PASS_LIMIT)) return GAIN_ONE;
      uy = (y < 0) ? -y : y;
      ni = uy >> 16;
      fr = uy & 64'hFFFF;
      if (fr == 0) begin
         m = Q30_1;
         sh = ni;
      end else begin
         m = pow2_frac(65536 - fr, 16);
         sh = ni + 1;
      end
      t = (sh < 63) ? (m >> sh) : 0;
      x = Q30_1 + t;
      l1 = (x >= Q30_2) ? 65536 : log2_mant(x);
      h = ((y > 0) ? longint'(y) : 0) + l1;
      ip = h >> 17;
      fp = h & 64'h1FFFF;
      if (fp == 0) begin
         m = Q30_1;
         sh = ip;
      end else begin
         m = pow2_frac(131072 - fp, 17);
         sh = ip + 1;
      end
      total = 30 + int'(sh) - GAIN_FRAC;
      if (total <= 0) g = m << (-total);
      else if (total >= 63) g = 0;
      else g = (m + (64'd1 << (total - 1))) >> total;
      if (g > 64'(GAIN_ONE)) g = 64'(GAIN_ONE);
      return g[GAIN_W-1:0];
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (gain_queue.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual gain %0d",
                        $time, rsp_gain);
               errors++;
            end else begin
               logic [GAIN_W-1:0] exp_gain;
               exp_gain = gain_queue.pop_front();
               if (rsp_gain !== exp_gain) begin
                  $display("%0t: gain mismatch, expected %0d, actual %0d",
                           $time, exp_gain, rsp_gain);
                  errors++;
               end
            end
         end
         if (rsp_strobe || accepted_now) idle_cycles = 0;
         else idle_cycles++;
         accepted_now = 0;
         if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // drive one request and wait for it to be taken
   task automatic send_freq(logic [FREQ_W-1:0] f, int exp_gain);
      logic [GAIN_W-1:0] pred;
      @(negedge clock);
      start <= 1'b1;
      req_freq <= f;
      do @(posedge clock); while (busy);
      pred = predict_gain(f, cur_cutoff, cur_order);
      if (exp_gain != NO_CHECK && pred !== GAIN_W'(exp_gain)) begin
         $display("%0t: table row freq %0d, expected %0d, predictor %0d",
                  $time, $signed(f), exp_gain, pred);
         errors++;
      end
      gain_queue.push_back(pred);
      accepted_now = 1;
   endtask

   task automatic pause_requests(int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // stop, let every request come back, then let the pipe settle
   task automatic drain;
      pause_requests(0);
      while (gain_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CUTOFF) cur_cutoff = val[CUT_W-1:0];
      else cur_order = val[ORD_W-1:0];
   endtask

   task automatic set_filter(logic [CUT_W-1:0] fc, logic [ORD_W-1:0] n);
      drain();
      write_reg(CSR_CUTOFF, CSR_DATA_W'(fc));
      write_reg(CSR_ORDER, CSR_DATA_W'(n));
   endtask

   typedef struct {
      logic [CUT_W-1:0]  cutoff;
      logic [ORD_W-1:0]  order;
      logic [FREQ_W-1:0] freq;
      int                gain;
   } row_type;

   row_type table_rows[$];

   function automatic logic [FREQ_W-1:0] random_freq(logic [CUT_W-1:0] fc);
      logic [FREQ_W-1:0] f;
      case ($urandom_range(0, 5))
         0: f = FREQ_W'($urandom);
         1: f = FREQ_W'($urandom_range(0, 64));
         2: f = FREQ_W'(fc) + FREQ_W'($urandom_range(0, 64)) - 24'd32;
         3: f = FREQ_W'(fc >> $urandom_range(0, 6));
         4: f = FREQ_W'({1'b0, fc} << $urandom_range(0, 2)) + FREQ_W'($urandom_range(0, 3));
         default: f = FREQ_W'($urandom) >> $urandom_range(0, 23);
      endcase
      if ($urandom_range(0, 1)) f = ~f + 1'b1;
      return f;
   endfunction

   initial begin
      logic [CUT_W-1:0] fc;
      logic [ORD_W-1:0] n;
      int burst;
      reset = 1'b1;
      start = 1'b0;
      req_freq = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0;
      idle_cycles = 0;
      accepted_now = 0;
      cur_cutoff = CUTOFF_RESET;
      cur_order = ORDER_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table: reset registers first
      table_rows = '{
         '{CUTOFF_RESET, ORDER_RESET, 24'd0, 65536},
         '{CUTOFF_RESET, ORDER_RESET, 24'd1048576, NO_CHECK},
         '{CUTOFF_RESET, ORDER_RESET, -24'sd1048576, NO_CHECK},
         '{CUTOFF_RESET, ORDER_RESET, 24'd1, NO_CHECK},
         '{CUTOFF_RESET, ORDER_RESET, 24'h7FFFFF, NO_CHECK},
         '{CUTOFF_RESET, ORDER_RESET, 24'h800000, NO_CHECK},
         '{23'd0, 8'd3, 24'd0, 0},
         '{23'd0, 8'd3, 24'h800000, 0},
         '{23'd0, 8'd3, 24'd77, 0},
         '{23'd1, 8'd255, 24'h7FFFFF, 0},
         '{23'd1, 8'd255, 24'h800000, 0},
         '{23'd1, 8'd255, 24'd1, NO_CHECK},
         '{23'd1, 8'd255, 24'hFFFFFF, NO_CHECK},
         '{23'd1, 8'd255, 24'd0, 65536},
         '{23'h7FFFFF, 8'd255, 24'd1, 65536},
         '{23'h7FFFFF, 8'd255, 24'h7FFFFE, NO_CHECK},
         '{23'h7FFFFF, 8'd255, 24'h800000, NO_CHECK},
         '{23'd1000, 8'd0, 24'd12345, NO_CHECK},
         '{23'd1000, 8'd0, 24'd1000, NO_CHECK},
         '{23'd1000, 8'd4, 24'd1000, NO_CHECK},
         '{23'd1000, 8'd4, 24'd1200, NO_CHECK},
         '{23'd1000, 8'd4, -24'sd800, NO_CHECK},
         '{23'd1000, 8'd4, 24'd40000, NO_CHECK}
      };
      foreach (table_rows[i]) begin
         if (table_rows[i].cutoff != cur_cutoff || table_rows[i].order != cur_order)
            set_filter(table_rows[i].cutoff, table_rows[i].order);
         send_freq(table_rows[i].freq, table_rows[i].gain);
      end

      // random phases, the register extremes among them
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin fc = 23'h7FFFFF; n = 8'd1; end
            1: begin fc = 23'd1; n = 8'd1; end
            2: begin fc = 23'd0; n = 8'd9; end
            3: begin fc = 23'd4096; n = 8'd255; end
            4: begin fc = CUT_W'($urandom); n = 8'd0; end
            default: begin
               fc = CUT_W'($urandom >> $urandom_range(0, 20));
               n = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 8));
            end
         endcase
         set_filter(fc, n);
         for (int k = 0; k < 50; ) begin
            burst = $urandom_range(1, 16);
            for (int b = 0; b < burst && k < 50; b++, k++)
               send_freq(random_freq(cur_cutoff), NO_CHECK);
            if ($urandom_range(0, 2) != 0) pause_requests($urandom_range(1, 20));
         end
      end

      drain();
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
